@@ rtl/crcpsf_pkg.sv @@
`timescale 1ns / 1ps

package crcpsf_pkg;

    localparam int unsigned ALIGN_BYTES = 4;
    localparam int unsigned CRC_BYTES   = 4;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [31:0] data_length;
        logic [31:0] storage_length;
    } out_word_t;

    typedef struct packed {
        logic       is_close;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/crc32_padded_segment_framer_unit.sv @@
`timescale 1ns / 1ps
// channel | ports                      | carries
// input   | s_valid, s_ready, s_data   | opcode + data byte (in_word_t)
// output  | m_valid, m_ready, m_data   | one emitted byte + end mark, lengths
//
// A write word yields one output byte; writes stream at one per cycle while
// the output is not stalled. A close emits 0 to 3 zero pad bytes and the
// four CRC bytes, one per cycle while the output register drains.
// A 4-entry command queue takes input while the output side is stalled.
// aresetn is synchronous, active low; it restores CRC and byte count.

module crc32_padded_segment_framer_unit
    import crcpsf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head_cmd;

    crcpsf_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    crcpsf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    crcpsf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head_cmd (head_cmd),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/crcpsf_queue.sv @@
`timescale 1ns / 1ps

module crcpsf_queue
    import crcpsf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head_cmd,
    output q_status_t status
);

    cmd_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign status.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                entries_reg[wr_ptr_reg] <= push_cmd;
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ rtl/crcpsf_front.sv @@
`timescale 1ns / 1ps

module crcpsf_front
    import crcpsf_pkg::*;
(
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    input  q_status_t q_status,
    output logic      push,
    output cmd_t      push_cmd
);

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_cmd.is_close = (s_data.opcode == OP_CLOSE);
        // data byte is don't-care on close; zero it
        push_cmd.data     = (s_data.opcode == OP_WRITE) ? s_data.data_byte : 8'd0;
    end

endmodule

@@ rtl/crcpsf_back.sv @@
`timescale 1ns / 1ps

module crcpsf_back
    import crcpsf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  q_status_t q_status,
    input  cmd_t      head_cmd,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    typedef enum logic {
        ST_RUN,
        ST_CLOSE
    } state_t;

    state_t      state_reg;
    logic [31:0] crc_reg;
    logic [31:0] count_reg;
    logic [1:0]  pad_rem_reg;
    logic [1:0]  crc_idx_reg;
    logic [31:0] slen_reg;
    logic        m_valid_reg;
    out_word_t   m_data_reg;

    logic        slot_free;
    logic        load_out;
    logic [1:0]  pad_calc;
    logic [32:0] slen_sum;
    logic [31:0] slen_calc;
    logic [31:0] crc_out;
    logic [7:0]  crc_byte;

    assign slot_free = !m_valid_reg || m_ready;
    assign pop       = (state_reg == ST_RUN) && !q_status.empty && slot_free;
    assign load_out  = pop ? !head_cmd.is_close : ((state_reg == ST_CLOSE) && slot_free);

    always_comb begin
        pad_calc  = 2'(2'd0 - count_reg[1:0]);
        slen_sum  = {1'b0, count_reg} + 33'(pad_calc) + 33'(CRC_BYTES);
        slen_calc = slen_sum[32] ? 32'hFFFF_FFFF : slen_sum[31:0];
        crc_out   = ~crc_reg;
        crc_byte  = 8'(crc_out >> {~crc_idx_reg, 3'b000});
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            crc_reg     <= CRC_INIT;
            count_reg   <= '0;
            pad_rem_reg <= '0;
            crc_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && !load_out) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN: begin
                    if (pop) begin
                        if (head_cmd.is_close) begin
                            state_reg   <= ST_CLOSE;
                            pad_rem_reg <= pad_calc;
                            crc_idx_reg <= '0;
                            slen_reg    <= slen_calc;
                        end else begin
                            crc_reg     <= crc_fold(crc_reg, head_cmd.data);
                            if (count_reg != 32'hFFFF_FFFF) begin
                                count_reg <= count_reg + 32'd1;
                            end
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= '{out_byte: head_cmd.data, out_last: 1'b0,
                                             data_length: 32'd0, storage_length: 32'd0};
                        end
                    end
                end
                ST_CLOSE: begin
                    if (slot_free) begin
                        m_valid_reg <= 1'b1;
                        if (pad_rem_reg != 2'd0) begin
                            crc_reg     <= crc_fold(crc_reg, 8'd0);
                            pad_rem_reg <= pad_rem_reg - 2'd1;
                            m_data_reg  <= '{out_byte: 8'd0, out_last: 1'b0,
                                             data_length: 32'd0, storage_length: 32'd0};
                        end else if (crc_idx_reg == 2'(CRC_BYTES - 1)) begin
                            m_data_reg  <= '{out_byte: crc_byte, out_last: 1'b1,
                                             data_length: count_reg,
                                             storage_length: slen_reg};
                            crc_reg     <= CRC_INIT;
                            count_reg   <= '0;
                            state_reg   <= ST_RUN;
                        end else begin
                            m_data_reg  <= '{out_byte: crc_byte, out_last: 1'b0,
                                             data_length: 32'd0, storage_length: 32'd0};
                            crc_idx_reg <= crc_idx_reg + 2'd1;
                        end
                    end
                end
                default: state_reg <= ST_RUN;
            endcase
        end
    end

endmodule

@@ rtl/crcpsf_checker.sv @@
`timescale 1ns / 1ps

module crcpsf_checker
    import crcpsf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output word changed");

    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_last |->
            m_data.data_length == 32'd0 && m_data.storage_length == 32'd0)
        else $error("lengths nonzero on non-final word");

    a_len_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_last |->
            m_data.storage_length[1:0] == 2'b00 ||
            m_data.storage_length == 32'hFFFF_FFFF)
        else $error("storage length not word aligned");

endmodule

bind crc32_padded_segment_framer_unit crcpsf_checker u_chk (.*);
